// ----- sv/ogru_pkg.sv -----
// Shared types and constants for the occupancy grid ray update block.
`timescale 1ns / 1ps
package ogru_pkg;
  localparam int RowBits = 8;
  localparam int ColBits = 8;
  localparam int AddrBits = RowBits + ColBits;
  localparam int Cells = 1 << AddrBits;

  localparam logic [1:0] ModeHit = 2'd0;
  localparam logic [1:0] ModeRay = 2'd1;
  localparam logic [1:0] ModeCommit = 2'd2;
  localparam logic [1:0] ModeQuery = 2'd3;

  typedef struct packed {
    logic [1:0] mode;
    logic [RowBits-1:0] target_row;
    logic [ColBits-1:0] target_col;
    logic [RowBits-1:0] start_row;
    logic [ColBits-1:0] start_col;
  } cmd_t;

  // Classified ray job: walk axis a from a0 up to a1 (excluded), other axis b.
  typedef struct packed {
    logic [1:0] mode;
    logic [RowBits-1:0] qrow;
    logic [ColBits-1:0] qcol;
    logic rows_step;
    logic [8:0] a0;
    logic [8:0] a1;
    logic [8:0] b0;
    logic [9:0] err0;
    logic [9:0] inc_pos;
    logic [9:0] inc_neg;
    logic b_dec;
  } job_t;
endpackage

// ----- sv/occupancy_grid_ray_update.sv -----
// Top level of the occupancy grid ray update block.
// Commands enter on start while busy is low; each gives one result word,
// shown for one cycle with done high, which the receiver cannot stall.
// mode 0 marks a hit cell in the scan grid, mode 1 walks a Bresenham ray
// and marks free cells, mode 2 adds the scan grid into the map with
// saturation and clears it, mode 3 reads a map cell.
// A front stage computes the ray terms and holds two commands in a queue;
// a back stage owns both grids of 65536 cells, each with one read and one
// write per cycle.
// A ray walk reads and then writes each walked cell in turn; a commit sweeps
// every cell of both grids, reading one address while writing back the last.
// After reset a clearing pass zeroes both grids; busy is high
// during it and no command is taken.
`timescale 1ns / 1ps
module occupancy_grid_ray_update import ogru_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic [1:0] mode,
  input  logic [7:0] target_row,
  input  logic [7:0] target_col,
  input  logic [7:0] start_row,
  input  logic [7:0] start_col,
  output logic done,
  output logic occupied,
  output logic [3:0] cell_logodds,
  output logic [8:0] cells_written
);
  cmd_t cmd;
  job_t job;
  logic full, job_valid, job_pop, clearing;

  assign cmd = '{mode, target_row, target_col, start_row, start_col};
  assign busy = full || clearing;

  ogru_front u_front (
    .clk(clk), .rst(rst), .in_valid(start && !busy), .in_cmd(cmd),
    .full(full), .job_pop(job_pop), .job_valid(job_valid), .job(job)
  );

  ogru_back u_back (
    .clk(clk), .rst(rst), .job_valid(job_valid), .job(job), .job_pop(job_pop),
    .clearing(clearing), .done(done), .occupied(occupied),
    .cell_logodds(cell_logodds), .cells_written(cells_written)
  );
endmodule

// ----- sv/ogru_front.sv -----
// Front end: accepts commands, sets up Bresenham terms, queues jobs.
`timescale 1ns / 1ps
module ogru_front import ogru_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  cmd_t in_cmd,
  output logic full,
  input  logic job_pop,
  output logic job_valid,
  output job_t job
);
  job_t q [2];
  logic [1:0] cnt;
  logic wp, rp;
  job_t j;
  logic signed [9:0] dr, dc, adr, adc, da, db, err;
  logic rev;

  always_comb begin
    dr = $signed({2'b00, in_cmd.target_row}) - $signed({2'b00, in_cmd.start_row});
    dc = $signed({2'b00, in_cmd.target_col}) - $signed({2'b00, in_cmd.start_col});
    adr = dr[9] ? -dr : dr;
    adc = dc[9] ? -dc : dc;
    j = '0;
    j.mode = in_cmd.mode;
    j.qrow = in_cmd.target_row;
    j.qcol = in_cmd.target_col;
    j.rows_step = !(adr < adc);
    if (adr < adc) begin
      rev = dc[9];
      da = adc;
      db = adr;
      j.a0 = {1'b0, rev ? in_cmd.target_col : in_cmd.start_col};
      j.a1 = {1'b0, rev ? in_cmd.start_col : in_cmd.target_col};
      j.b0 = {1'b0, rev ? in_cmd.target_row : in_cmd.start_row};
      j.b_dec = rev ? !dr[9] : dr[9];
    end else begin
      rev = dr[9];
      da = adr;
      db = adc;
      j.a0 = {1'b0, rev ? in_cmd.target_row : in_cmd.start_row};
      j.a1 = {1'b0, rev ? in_cmd.start_row : in_cmd.target_row};
      j.b0 = {1'b0, rev ? in_cmd.target_col : in_cmd.start_col};
      j.b_dec = rev ? !dc[9] : dc[9];
    end
    err = 10'(2 * db) - da;
    j.inc_pos = 10'(2 * (db - da));
    j.inc_neg = 10'(2 * db);
    // The reversed walk takes one extra error step before its first cell.
    if (rev) begin
      if (err > 0) begin
        j.b0 = j.b_dec ? j.b0 - 9'd1 : j.b0 + 9'd1;
        err = err + j.inc_pos;
      end else begin
        err = err + j.inc_neg;
      end
    end
    j.err0 = err;
  end

  assign full = cnt[1];
  assign job_valid = cnt != 2'd0;
  assign job = q[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      wp <= 1'b0;
      rp <= 1'b0;
    end else begin
      if (in_valid) begin
        q[wp] <= j;
        wp <= !wp;
      end
      if (job_pop) rp <= !rp;
      cnt <= cnt + 2'(in_valid) - 2'(job_pop);
    end
  end
endmodule

// ----- sv/ogru_back.sv -----
// Back end: runs hit marks, ray walks, commits and queries on the two grids.
`timescale 1ns / 1ps
module ogru_back import ogru_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic job_valid,
  input  job_t job,
  output logic job_pop,
  output logic clearing,
  output logic done,
  output logic occupied,
  output logic [3:0] cell_logodds,
  output logic [8:0] cells_written
);
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRead = 3'd1;
  localparam logic [2:0] StWrite = 3'd2;
  localparam logic [2:0] StClear = 3'd3;
  localparam logic [2:0] StDone = 3'd4;

  logic signed [3:0] map_mem [Cells];
  logic signed [4:0] scan_mem [Cells];
  logic signed [3:0] map_rd;
  logic signed [4:0] scan_rd;

  logic [2:0] state;
  job_t cur;
  logic [8:0] a, b;
  logic signed [9:0] err;
  logic [AddrBits:0] sweep;
  logic [8:0] count;
  logic cell_ok;
  logic [AddrBits-1:0] addr;
  logic [AddrBits-1:0] rd_addr;
  logic [8:0] nb;
  logic signed [9:0] nerr;
  logic signed [5:0] sum;
  logic signed [3:0] sat;

  assign job_pop = (state == StIdle) && job_valid;
  assign clearing = (state == StClear) && cur.mode != ModeCommit;

  // Error step for the next walk cell, and the saturated map plus scan sum for a commit.
  always_comb begin
    if (err > 0) begin
      nb = cur.b_dec ? b - 9'd1 : b + 9'd1;
      nerr = err + cur.inc_pos;
    end else begin
      nb = b;
      nerr = err + cur.inc_neg;
    end
    sum = 6'(map_rd) + 6'(scan_rd);
    if (sum > 6'sd5) sat = 4'sd5;
    else if (sum <= -6'sd5) sat = -4'sd5;
    else sat = sum[3:0];
  end

  always_comb begin
    if (cur.rows_step) begin
      rd_addr = {a[7:0], nb[7:0]};
      cell_ok = !nb[8];
    end else begin
      rd_addr = {nb[7:0], a[7:0]};
      cell_ok = !nb[8];
    end
    addr = rd_addr;
  end

  always_ff @(posedge clk) begin
    if (state == StRead) begin
      scan_rd <= scan_mem[addr];
    end else if (state == StIdle) begin
      scan_rd <= scan_mem[{job.qrow, job.qcol}];
      map_rd <= map_mem[{job.qrow, job.qcol}];
    end else if (state == StClear) begin
      scan_rd <= scan_mem[sweep[AddrBits-1:0]];
      map_rd <= map_mem[sweep[AddrBits-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StClear;
      sweep <= '0;
      cur.mode <= ModeHit;
      done <= 1'b0;
    end else begin
      done <= (state == StDone);
      case (state)
        StIdle: begin
          if (job_valid) begin
            cur <= job;
            a <= job.a0;
            b <= job.b0;
            err <= job.err0;
            count <= '0;
            sweep <= '0;
            case (job.mode)
              ModeRay: state <= (job.a0 < job.a1) ? StRead : StDone;
              ModeCommit: state <= StClear;
              default: state <= StWrite;
            endcase
          end
        end
        StRead: state <= StWrite;
        StWrite: begin
          case (cur.mode)
            ModeHit: begin
              if (scan_rd < 5'sd10) begin
                scan_mem[{cur.qrow, cur.qcol}] <= scan_rd + 5'sd2;
                count <= 9'd1;
              end
              state <= StDone;
            end
            ModeRay: begin
              if (cell_ok && scan_rd > -5'sd10 && scan_rd <= 5'sd0) begin
                scan_mem[addr] <= scan_rd - 5'sd2;
                count <= count + 9'd1;
              end
              a <= a + 9'd1;
              b <= nb;
              err <= nerr;
              state <= (a + 9'd1 < cur.a1) ? StRead : StDone;
            end
            default: state <= StDone;
          endcase
        end
        StClear: begin
          // Sweep pipeline: read at sweep, write back at the address sweep minus one.
          if (sweep != '0) begin
            if (cur.mode == ModeCommit) map_mem[AddrBits'(sweep - 1'b1)] <= sat;
            else map_mem[AddrBits'(sweep - 1'b1)] <= '0;
            scan_mem[AddrBits'(sweep - 1'b1)] <= '0;
          end
          sweep <= sweep + 1'b1;
          if (sweep == (AddrBits+1)'(Cells)) begin
            state <= (cur.mode == ModeCommit) ? StDone : StIdle;
          end
        end
        StDone: begin
          occupied <= (cur.mode == ModeQuery) && map_rd > 4'sd0;
          cell_logodds <= (cur.mode == ModeQuery) ? map_rd : 4'd0;
          cells_written <= (cur.mode == ModeHit || cur.mode == ModeRay) ? count : 9'd0;
          state <= StIdle;
        end
        default: state <= StIdle;
      endcase
    end
  end
endmodule
